// ----- hw/rtl/tlbra_pkg.sv -----
// Shared constants, types and address helpers for the bitmap rank allocator.
package tlbra_pkg;

  // Geometry bounds of one bank
  localparam int MAX_ROWS      = 256;
  localparam int MAX_COLS      = 256;
  localparam int WORD_BITS     = 64;
  localparam int WORD_BW       = $clog2(WORD_BITS);
  localparam int WORDS_PER_ROW = (MAX_COLS + WORD_BITS - 1) / WORD_BITS;
  localparam int BYTES_PER_WORD = WORD_BITS / 8;
  localparam int BYTE_CW       = $clog2(BYTES_PER_WORD);

  // Bitmap memory: both banks, row-major, one word per entry
  localparam int MAP_DEPTH = 2 * MAX_ROWS * WORDS_PER_ROW;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);

  // Row used-count memory: one entry per row and bank
  localparam int CNT_DEPTH = 2 * MAX_ROWS;
  localparam int CNT_AW    = $clog2(CNT_DEPTH);

  // Field and register widths
  localparam int CFG_W      = 9;
  localparam int WORD_CW    = CFG_W - WORD_BW;
  localparam int AREA_W     = 2 * CFG_W;
  localparam int RANK_W     = 17;
  localparam int IDX_W      = 8;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;
  localparam int IN_USER_W  = 2;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [RANK_W-1:0] FREE_MAX = {RANK_W{1'b1}};
  localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(256);

  // Command codes
  localparam logic CMD_SELECT = 1'b0;
  localparam logic CMD_MARK   = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_USED    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd3;

  // Register indexes (paddr word select)
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // Geometry handed from the register block to the engine
  typedef struct packed {
    logic [CFG_W-1:0]  nrows;
    logic [CFG_W-1:0]  ncols;
    logic [AREA_W-1:0] area;
    logic              clear;
  } cfg_t;

  // Bitmap word address of (bank, row, word)
  function automatic logic [MAP_AW-1:0] map_addr(input logic bank,
                                                 input logic [CFG_W-1:0] row,
                                                 input logic [WORD_CW-1:0] word);
    int a;
    a = int'(bank) * MAX_ROWS * WORDS_PER_ROW + int'(row) * WORDS_PER_ROW + int'(word);
    return MAP_AW'(a);
  endfunction

  // Row count address of (bank, row)
  function automatic logic [CNT_AW-1:0] cnt_addr(input logic bank,
                                                 input logic [CFG_W-1:0] row);
    int a;
    a = int'(bank) * MAX_ROWS + int'(row);
    return CNT_AW'(a);
  endfunction

  // Free slots of a bank, clamped at zero and at the field width
  function automatic logic [RANK_W-1:0] free_calc(input logic [AREA_W-1:0] area,
                                                  input logic [AREA_W-1:0] used);
    logic [AREA_W-1:0] diff;
    diff = (used >= area) ? '0 : area - used;
    return (diff > AREA_W'(FREE_MAX)) ? FREE_MAX : RANK_W'(diff);
  endfunction

endpackage

// ----- hw/rtl/tlbra_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module tlbra_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/tlbra_cfg.sv -----
// Register block: geometry registers, bank area and clear request.
module tlbra_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tlbra_pkg::PADDR_W-1:0]    paddr,
  input  logic [tlbra_pkg::PDATA_W-1:0]    pwdata,
  output logic [tlbra_pkg::PDATA_W-1:0]    prdata,
  output logic                             pready,
  output tlbra_pkg::cfg_t                  cfg
);

  logic [tlbra_pkg::CFG_W-1:0] rows_in_use;
  logic [tlbra_pkg::CFG_W-1:0] cols_in_use;
  logic [tlbra_pkg::CFG_W-1:0] eff_rows;
  logic [tlbra_pkg::CFG_W-1:0] eff_cols;
  logic [tlbra_pkg::AREA_W-1:0] area;
  logic                         clear;
  logic                         wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  // Store writes; any geometry write asks for a clear of both banks
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= tlbra_pkg::CFG_RESET;
      cols_in_use <= tlbra_pkg::CFG_RESET;
      clear       <= 1'b0;
    end else begin
      clear <= wr;
      if (wr) begin
        case (paddr[2])
          tlbra_pkg::REG_ROWS: rows_in_use <= pwdata[tlbra_pkg::CFG_W-1:0];
          tlbra_pkg::REG_COLS: cols_in_use <= pwdata[tlbra_pkg::CFG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Clamp geometry to the storage bounds
  always_comb begin
    eff_rows = (int'(rows_in_use) > tlbra_pkg::MAX_ROWS) ?
               tlbra_pkg::CFG_W'(tlbra_pkg::MAX_ROWS) : rows_in_use;
    eff_cols = (int'(cols_in_use) > tlbra_pkg::MAX_COLS) ?
               tlbra_pkg::CFG_W'(tlbra_pkg::MAX_COLS) : cols_in_use;
  end

  // Register the bank area
  always_ff @(posedge clk) begin
    area <= tlbra_pkg::AREA_W'(eff_rows) * tlbra_pkg::AREA_W'(eff_cols);
  end

  // Read back
  always_comb begin
    case (paddr[2])
      tlbra_pkg::REG_ROWS: prdata = tlbra_pkg::PDATA_W'(rows_in_use);
      tlbra_pkg::REG_COLS: prdata = tlbra_pkg::PDATA_W'(cols_in_use);
      default:             prdata = '0;
    endcase
  end

  assign cfg.nrows = eff_rows;
  assign cfg.ncols = eff_cols;
  assign cfg.area  = area;
  assign cfg.clear = clear;

endmodule

// ----- hw/rtl/tlbra_engine.sv -----
// Command engine: clear sweep, mark read-modify-write and rank select scan.
module tlbra_engine (
  input  logic                                clk,
  input  logic                                rst,
  input  tlbra_pkg::cfg_t                     cfg,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [tlbra_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic [tlbra_pkg::IN_USER_W-1:0]     s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [tlbra_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic [tlbra_pkg::STATUS_W-1:0]      m_tuser
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MARK,
    S_ROW,
    S_LOAD,
    S_BYTE,
    S_DONE
  } state_t;

  state_t state;

  logic [tlbra_pkg::MAP_AW-1:0]    clr_idx;
  logic                            bank_q;
  logic [tlbra_pkg::IDX_W-1:0]     row_q;
  logic [tlbra_pkg::IDX_W-1:0]     col_q;
  logic [tlbra_pkg::RANK_W-1:0]    k_q;
  logic [tlbra_pkg::CFG_W-1:0]     row_ctr;
  logic [tlbra_pkg::WORD_CW-1:0]   word_ctr;
  logic [tlbra_pkg::BYTE_CW-1:0]   byte_ctr;
  logic [tlbra_pkg::WORD_BITS-1:0] wreg;
  logic [tlbra_pkg::STATUS_W-1:0]  status_q;
  logic [tlbra_pkg::IDX_W-1:0]     frow_q;
  logic [tlbra_pkg::IDX_W-1:0]     fcol_q;
  logic [tlbra_pkg::AREA_W-1:0]    used_total [2];

  // Input word fields
  logic                          in_cmd;
  logic                          in_bank;
  logic [tlbra_pkg::RANK_W-1:0]  in_rank;
  logic [tlbra_pkg::IDX_W-1:0]   in_row;
  logic [tlbra_pkg::IDX_W-1:0]   in_col;
  logic [tlbra_pkg::RANK_W-1:0]  free_in;

  // Memory ports
  logic                            map_we;
  logic [tlbra_pkg::MAP_AW-1:0]    map_waddr;
  logic [tlbra_pkg::WORD_BITS-1:0] map_wdata;
  logic [tlbra_pkg::MAP_AW-1:0]    map_raddr;
  logic [tlbra_pkg::WORD_BITS-1:0] map_rdata;
  logic                            cnt_we;
  logic [tlbra_pkg::CNT_AW-1:0]    cnt_waddr;
  logic [tlbra_pkg::CFG_W-1:0]     cnt_wdata;
  logic [tlbra_pkg::CNT_AW-1:0]    cnt_raddr;
  logic [tlbra_pkg::CFG_W-1:0]     cnt_rdata;

  // Scan helpers
  logic [tlbra_pkg::CFG_W-1:0]     row_free;
  logic                            row_last;
  logic                            word_last;
  logic                            byte_last;
  logic                            bit_set;
  logic [tlbra_pkg::WORD_CW-1:0]   mark_word;
  logic [7:0]                      free_bits;
  logic [3:0]                      zeros;
  logic                            hit;
  logic [2:0]                      hit_bit;
  logic [3:0]                      run;
  logic [tlbra_pkg::CFG_W-1:0]     bit_col;
  logic [tlbra_pkg::RANK_W-1:0]    free_now;
  logic                            out_load;

  assign in_cmd  = s_tuser[0];
  assign in_bank = s_tuser[1];
  assign in_rank = s_tdata[16:0];
  assign in_row  = s_tdata[24:17];
  assign in_col  = s_tdata[32:25];

  assign s_tready = (state == S_IDLE);
  assign free_in  = tlbra_pkg::free_calc(cfg.area, used_total[in_bank]);
  assign free_now = tlbra_pkg::free_calc(cfg.area, used_total[bank_q]);

  // Load the result register once the command is done, the register is free and no clear is pending
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready) && !cfg.clear;

  tlbra_ram #(
    .DEPTH (tlbra_pkg::MAP_DEPTH),
    .WIDTH (tlbra_pkg::WORD_BITS)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  tlbra_ram #(
    .DEPTH (tlbra_pkg::CNT_DEPTH),
    .WIDTH (tlbra_pkg::CFG_W)
  ) u_cnt (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // Row and word bounds of the scan
  always_comb begin
    row_free  = (cnt_rdata >= cfg.ncols) ? '0 : cfg.ncols - cnt_rdata;
    row_last  = ({1'b0, row_ctr} + 10'd1) >= {1'b0, cfg.nrows};
    word_last = {({1'b0, word_ctr} + 4'd1), 6'b0} >= {1'b0, cfg.ncols};
    byte_last = (byte_ctr == tlbra_pkg::BYTE_CW'(tlbra_pkg::BYTES_PER_WORD - 1));
    mark_word = tlbra_pkg::WORD_CW'(col_q[tlbra_pkg::IDX_W-1:tlbra_pkg::WORD_BW]);
    bit_set   = map_rdata[col_q[tlbra_pkg::WORD_BW-1:0]];
  end

  // Count free bits of the current byte and locate the k-th one
  always_comb begin
    zeros   = '0;
    hit     = 1'b0;
    hit_bit = '0;
    run     = '0;
    for (int b = 0; b < 8; b++) begin
      free_bits[b] = !wreg[b] && ({word_ctr, byte_ctr, 3'(b)} < cfg.ncols);
      if (free_bits[b]) begin
        zeros = zeros + 4'd1;
        if (!hit) begin
          run = run + 4'd1;
          if (tlbra_pkg::RANK_W'(run) == k_q) begin
            hit     = 1'b1;
            hit_bit = 3'(b);
          end
        end
      end
    end
    bit_col = {word_ctr, byte_ctr, hit_bit};
  end

  // Drive memory ports by state
  always_comb begin
    map_we    = 1'b0;
    map_waddr = '0;
    map_wdata = '0;
    map_raddr = '0;
    cnt_we    = 1'b0;
    cnt_waddr = '0;
    cnt_wdata = '0;
    cnt_raddr = '0;
    case (state)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_idx;
        cnt_we    = (int'(clr_idx) < tlbra_pkg::CNT_DEPTH);
        cnt_waddr = clr_idx[tlbra_pkg::CNT_AW-1:0];
      end
      S_IDLE: begin
        map_raddr = tlbra_pkg::map_addr(in_bank, tlbra_pkg::CFG_W'(in_row),
                      tlbra_pkg::WORD_CW'(in_col[tlbra_pkg::IDX_W-1:tlbra_pkg::WORD_BW]));
        cnt_raddr = (in_cmd == tlbra_pkg::CMD_MARK) ?
                    tlbra_pkg::cnt_addr(in_bank, tlbra_pkg::CFG_W'(in_row)) :
                    tlbra_pkg::cnt_addr(in_bank, '0);
      end
      S_MARK: begin
        map_we    = !bit_set;
        map_waddr = tlbra_pkg::map_addr(bank_q, tlbra_pkg::CFG_W'(row_q), mark_word);
        map_wdata = map_rdata |
                    (tlbra_pkg::WORD_BITS'(1) << col_q[tlbra_pkg::WORD_BW-1:0]);
        cnt_we    = !bit_set;
        cnt_waddr = tlbra_pkg::cnt_addr(bank_q, tlbra_pkg::CFG_W'(row_q));
        cnt_wdata = cnt_rdata + tlbra_pkg::CFG_W'(1);
      end
      S_ROW: begin
        cnt_raddr = tlbra_pkg::cnt_addr(bank_q, row_ctr + tlbra_pkg::CFG_W'(1));
        map_raddr = tlbra_pkg::map_addr(bank_q, row_ctr, '0);
      end
      S_BYTE: begin
        map_raddr = tlbra_pkg::map_addr(bank_q, row_ctr,
                                        word_ctr + tlbra_pkg::WORD_CW'(1));
      end
      default: ;
    endcase
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_idx       <= '0;
      m_tvalid      <= 1'b0;
      used_total[0] <= '0;
      used_total[1] <= '0;
    end else begin
      // Load a new result word, or drop the current one once taken
      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tuser  <= (status_q == tlbra_pkg::ST_OK) ? tlbra_pkg::ST_OK : status_q;
        m_tdata  <= tlbra_pkg::OUT_DATA_W'({free_now, fcol_q, frow_q});
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (cfg.clear) begin
        // Geometry change restarts the clear sweep
        state         <= S_CLEAR;
        clr_idx       <= '0;
        used_total[0] <= '0;
        used_total[1] <= '0;
      end else begin
        case (state)
          S_CLEAR: begin
            clr_idx <= clr_idx + tlbra_pkg::MAP_AW'(1);
            if (clr_idx == tlbra_pkg::MAP_AW'(tlbra_pkg::MAP_DEPTH - 1)) begin
              state <= S_IDLE;
            end
          end

          S_IDLE: begin
            if (s_tvalid) begin
              bank_q <= in_bank;
              row_q  <= in_row;
              col_q  <= in_col;
              k_q    <= in_rank;
              frow_q <= '0;
              fcol_q <= '0;
              if (in_cmd == tlbra_pkg::CMD_MARK) begin
                if ((tlbra_pkg::CFG_W'(in_row) >= cfg.nrows) ||
                    (tlbra_pkg::CFG_W'(in_col) >= cfg.ncols)) begin
                  status_q <= tlbra_pkg::ST_RANGE;
                  state    <= S_DONE;
                end else begin
                  state <= S_MARK;
                end
              end else begin
                if ((in_rank == '0) || (in_rank > free_in)) begin
                  status_q <= tlbra_pkg::ST_NO_FREE;
                  state    <= S_DONE;
                end else begin
                  row_ctr <= '0;
                  state   <= S_ROW;
                end
              end
            end
          end

          S_MARK: begin
            if (bit_set) begin
              status_q <= tlbra_pkg::ST_USED;
            end else begin
              status_q           <= tlbra_pkg::ST_OK;
              used_total[bank_q] <= used_total[bank_q] + tlbra_pkg::AREA_W'(1);
            end
            state <= S_DONE;
          end

          // Skip whole rows until the rank falls inside one
          S_ROW: begin
            if (k_q > tlbra_pkg::RANK_W'(row_free)) begin
              k_q <= k_q - tlbra_pkg::RANK_W'(row_free);
              if (row_last) begin
                status_q <= tlbra_pkg::ST_NO_FREE;
                state    <= S_DONE;
              end else begin
                row_ctr <= row_ctr + tlbra_pkg::CFG_W'(1);
              end
            end else begin
              word_ctr <= '0;
              state    <= S_LOAD;
            end
          end

          S_LOAD: begin
            wreg     <= map_rdata;
            byte_ctr <= '0;
            state    <= S_BYTE;
          end

          // Walk the word one byte a cycle
          S_BYTE: begin
            if (hit) begin
              status_q <= tlbra_pkg::ST_OK;
              frow_q   <= row_ctr[tlbra_pkg::IDX_W-1:0];
              fcol_q   <= bit_col[tlbra_pkg::IDX_W-1:0];
              state    <= S_DONE;
            end else begin
              k_q      <= k_q - tlbra_pkg::RANK_W'(zeros);
              wreg     <= wreg >> 8;
              byte_ctr <= byte_ctr + tlbra_pkg::BYTE_CW'(1);
              if (byte_last) begin
                if (word_last) begin
                  status_q <= tlbra_pkg::ST_NO_FREE;
                  state    <= S_DONE;
                end else begin
                  word_ctr <= word_ctr + tlbra_pkg::WORD_CW'(1);
                  state    <= S_LOAD;
                end
              end
            end
          end

          // Hand the result to the output register when it is free
          S_DONE: begin
            if (out_load) begin
              state <= S_IDLE;
            end
          end

          default: state <= S_IDLE;
        endcase
      end
    end
  end

endmodule

// ----- hw/rtl/two_level_bitmap_rank_allocator.sv -----
// Top level of the two-bank bitmap rank/select slot allocator.
// Steps: a mark reads the bitmap word and row count, then writes both if the slot is free;
// a select with a bad rank goes straight to the result; a select scan reads one row count
// per row, then loads each bitmap word of the found row and walks it in up to eight byte
// steps (the word read overlaps the previous step). Throughput: one word at a time; the
// next word is taken once the result is registered. Reset and every geometry write start
// a sweep clearing the bitmap and row count memories; input is held off during the sweep.
module two_level_bitmap_rank_allocator (
  input  logic                             clk,
  input  logic                             rst,
  // input word
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // s_tdata: rank[16:0], row_index[24:17], col_index[32:25], zero pad[39:33]
  input  logic [tlbra_pkg::IN_DATA_W-1:0]  s_tdata,
  // s_tuser: command[0], bank[1]
  input  logic [tlbra_pkg::IN_USER_W-1:0]  s_tuser,
  // result word
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // m_tdata: found_row[7:0], found_col[15:8], free_total[32:16], zero pad[39:33]
  output logic [tlbra_pkg::OUT_DATA_W-1:0] m_tdata,
  // m_tuser: status[1:0]
  output logic [tlbra_pkg::STATUS_W-1:0]   m_tuser,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tlbra_pkg::PADDR_W-1:0]    paddr,
  input  logic [tlbra_pkg::PDATA_W-1:0]    pwdata,
  output logic [tlbra_pkg::PDATA_W-1:0]    prdata,
  output logic                             pready
);

  tlbra_pkg::cfg_t cfg;

  tlbra_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tlbra_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ----- verif/two_level_bitmap_rank_allocator_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the two-bank bitmap rank/select slot allocator.
module two_level_bitmap_rank_allocator_tb;
  import tlbra_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int STALL_LIMIT = 20000;
  localparam int PHASE_WORDS = 100;
  localparam int NUM_PHASES  = 11;
  localparam int PAD_W       = IN_DATA_W - RANK_W - 2 * IDX_W;

  // Geometries of the random phases; some exceed the bounds to check saturation
  localparam int unsigned PHASE_ROWS [NUM_PHASES] =
    '{1, 4, 3, 8, 2, 6, 256, 300, 16, 5, 12};
  localparam int unsigned PHASE_COLS [NUM_PHASES] =
    '{1, 64, 65, 13, 256, 130, 256, 2, 200, 511, 70};

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    found_row;
    logic [IDX_W-1:0]    found_col;
    logic [RANK_W-1:0]   free_total;
  } slot_answer_t;

  // Tracks both bank bitmaps and the geometry, and holds the answers still due
  class rank_predictor;
    logic [MAX_COLS-1:0] slot_used [2][MAX_ROWS];
    int unsigned         row_marks [2][MAX_ROWS];
    int unsigned         bank_marks [2];
    logic [CFG_W-1:0]    rows_reg;
    logic [CFG_W-1:0]    cols_reg;
    slot_answer_t        answers_due [$];
    int unsigned         mismatches;
    int unsigned         words_in;
    int unsigned         status_seen [4];

    function new();
      rows_reg   = CFG_RESET;
      cols_reg   = CFG_RESET;
      mismatches = 0;
      words_in   = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (slot_used[b, r]) begin
        slot_used[b][r] = '0;
        row_marks[b][r] = 0;
      end
      bank_marks[0] = 0;
      bank_marks[1] = 0;
    endfunction

    function int unsigned active_rows();
      return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
    endfunction

    function int unsigned active_cols();
      return (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
    endfunction

    // Free slots of a bank, clamped at zero and at the field width
    function int unsigned free_slots(logic bank);
      int unsigned area;
      int unsigned left;
      area = active_rows() * active_cols();
      left = (bank_marks[bank] >= area) ? 0 : area - bank_marks[bank];
      return (left > FREE_MAX) ? int'(FREE_MAX) : left;
    endfunction

    // Any geometry write clears both banks
    function void set_geometry(logic idx, logic [CFG_W-1:0] value);
      if (idx == REG_ROWS) rows_reg = value;
      else cols_reg = value;
      wipe();
    endfunction

    function int unsigned pending();
      return answers_due.size();
    endfunction

    // Work out the answer to one accepted command word and apply its effect
    function void note_word(logic cmd, logic bank, logic [RANK_W-1:0] rank,
                            logic [IDX_W-1:0] row, logic [IDX_W-1:0] col);
      slot_answer_t a;
      int unsigned  nrows;
      int unsigned  ncols;
      int unsigned  k;
      int unsigned  left;
      int unsigned  r;
      int unsigned  c;
      a     = '0;
      nrows = active_rows();
      ncols = active_cols();
      words_in++;
      if (cmd == CMD_SELECT) begin
        k        = rank;
        a.status = ST_NO_FREE;
        if (k != 0 && k <= free_slots(bank)) begin
          // Skip whole rows by their free count, then walk the bitmap of the hit row
          for (r = 0; r < nrows; r++) begin
            left = (row_marks[bank][r] >= ncols) ? 0 : ncols - row_marks[bank][r];
            if (k > left) begin
              k -= left;
            end else begin
              for (c = 0; c < ncols; c++) begin
                if (!slot_used[bank][r][c]) begin
                  k--;
                  if (k == 0) begin
                    a.status    = ST_OK;
                    a.found_row = IDX_W'(r);
                    a.found_col = IDX_W'(c);
                    break;
                  end
                end
              end
              break;
            end
          end
        end
      end else if (row >= nrows || col >= ncols) begin
        a.status = ST_RANGE;
      end else if (slot_used[bank][row][col]) begin
        a.status = ST_USED;
      end else begin
        a.status = ST_OK;
        slot_used[bank][row][col] = 1'b1;
        row_marks[bank][row]++;
        bank_marks[bank]++;
      end
      a.free_total = RANK_W'(free_slots(bank));
      answers_due.insert(answers_due.size(), a);
    endfunction

    // Compare one result word with the oldest answer due
    function void check_word(slot_answer_t got);
      slot_answer_t want;
      if (answers_due.size() == 0) begin
        $error("result word with no answer due: status %0d row %0d col %0d free %0d",
               got.status, got.found_row, got.found_col, got.free_total);
        mismatches++;
        return;
      end
      want = answers_due.pop_front();
      status_seen[want.status]++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        mismatches++;
      end
      if (got.found_row !== want.found_row) begin
        $error("found_row: expected %0d, actual %0d", want.found_row, got.found_row);
        mismatches++;
      end
      if (got.found_col !== want.found_col) begin
        $error("found_col: expected %0d, actual %0d", want.found_col, got.found_col);
        mismatches++;
      end
      if (got.free_total !== want.free_total) begin
        $error("free_total: expected %0d, actual %0d", want.free_total, got.free_total);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  wire                   s_tready;
  // s_tdata: rank[16:0], row_index[24:17], col_index[32:25], zero pad[39:33]
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  // s_tuser: command[0], bank[1]
  logic [IN_USER_W-1:0]  s_tuser  = '0;
  wire                   m_tvalid;
  logic                  m_tready = 1'b0;
  // m_tdata: found_row[7:0], found_col[15:8], free_total[32:16], zero pad[39:33]
  wire [OUT_DATA_W-1:0]  m_tdata;
  // m_tuser: status[1:0]
  wire [STATUS_W-1:0]    m_tuser;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [PADDR_W-1:0]    paddr    = '0;
  logic [PDATA_W-1:0]    pwdata   = '0;
  wire [PDATA_W-1:0]     prdata;
  wire                   pready;

  bit                    calm = 1'b0;
  int unsigned           stall_left = 0;
  int unsigned           quiet_cycles = 0;
  rank_predictor         ledger;

  two_level_bitmap_rank_allocator i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Stall the result side in random bursts; hold ready high in the calm phase
  always @(posedge clk) begin
    if (rst || calm) begin
      m_tready   <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= (stall_left == 1);
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 10);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Check every accepted result word
  always @(posedge clk) begin : result_watch
    slot_answer_t seen;
    if (!rst && m_tvalid && m_tready) begin
      seen.status     = m_tuser;
      seen.found_row  = m_tdata[7:0];
      seen.found_col  = m_tdata[15:8];
      seen.free_total = m_tdata[32:16];
      ledger.check_word(seen);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one command word and hold it until accepted
  task automatic send_word(input logic cmd, input logic bank, input logic [RANK_W-1:0] rank,
                           input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col);
    s_tdata  <= {{PAD_W{1'b0}}, col, row, rank};
    s_tuser  <= {bank, cmd};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ledger.note_word(cmd, bank, rank, row, col);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop valid and wait until every answer due has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  // Write one geometry register over the config port, then wait out the clearing sweep
  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    ledger.set_geometry(idx, value);
    repeat (4) @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Mostly in-range marks and reachable ranks, with some noise
  task automatic random_word();
    logic              cmd;
    logic              bank;
    logic [RANK_W-1:0] rank;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    int unsigned       pick;
    int unsigned       nrows;
    int unsigned       ncols;
    int unsigned       spare;
    cmd   = 1'($urandom);
    bank  = 1'($urandom);
    rank  = RANK_W'($urandom);
    row   = IDX_W'($urandom);
    col   = IDX_W'($urandom);
    pick  = $urandom_range(0, 19);
    nrows = ledger.active_rows();
    ncols = ledger.active_cols();
    if (cmd == CMD_MARK) begin
      if (pick < 17 && nrows > 0 && ncols > 0) begin
        row = IDX_W'($urandom_range(0, nrows - 1));
        col = IDX_W'($urandom_range(0, ncols - 1));
      end
    end else begin
      spare = ledger.free_slots(bank);
      if (pick < 14 && spare > 0) rank = RANK_W'($urandom_range(1, spare));
      else if (pick < 17) rank = RANK_W'(spare + 1);
      else if (pick == 17) rank = '0;
    end
    send_word(cmd, bank, rank, row, col);
  endtask

  initial begin : stimulus
    int p;
    int n;
    ledger = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Full 256 x 256 geometry after reset: rank extremes and simple marks
    send_word(CMD_SELECT, 1'b0, 17'd0, 8'd0, 8'd0);
    send_word(CMD_SELECT, 1'b0, 17'd1, 8'd0, 8'd0);
    send_word(CMD_SELECT, 1'b0, 17'd65536, 8'd0, 8'd0);
    send_word(CMD_SELECT, 1'b0, 17'd65537, 8'd0, 8'd0);
    send_word(CMD_SELECT, 1'b1, 17'h1FFFF, 8'hFF, 8'hFF);
    send_word(CMD_MARK, 1'b0, 17'd0, 8'd0, 8'd0);
    send_word(CMD_MARK, 1'b0, 17'd0, 8'd0, 8'd0);
    send_word(CMD_SELECT, 1'b0, 17'd1, 8'd0, 8'd0);
    send_word(CMD_MARK, 1'b1, 17'h1FFFF, 8'd255, 8'd255);
    send_word(CMD_SELECT, 1'b1, 17'd65535, 8'd0, 8'd0);
    send_word(CMD_SELECT, 1'b1, 17'd65536, 8'd0, 8'd0);
    send_word(CMD_MARK, 1'b0, 17'h1FFFF, 8'd0, 8'd255);

    // Tiny 3 x 5 area: out-of-range marks on either index, last slot, rank past the end
    drain_results();
    write_reg(REG_ROWS, 9'd3);
    write_reg(REG_COLS, 9'd5);
    send_word(CMD_MARK, 1'b0, 17'd0, 8'd3, 8'd0);
    send_word(CMD_MARK, 1'b0, 17'd0, 8'd0, 8'd5);
    send_word(CMD_MARK, 1'b1, 17'd0, 8'd255, 8'd255);
    send_word(CMD_MARK, 1'b0, 17'd0, 8'd2, 8'd4);
    send_word(CMD_SELECT, 1'b0, 17'd14, 8'd0, 8'd0);
    send_word(CMD_SELECT, 1'b0, 17'd15, 8'd0, 8'd0);

    // Zero rows: the bank is empty
    drain_results();
    write_reg(REG_ROWS, 9'd0);
    send_word(CMD_SELECT, 1'b0, 17'd1, 8'd0, 8'd0);
    send_word(CMD_MARK, 1'b1, 17'd0, 8'd0, 8'd0);

    // Values above the bound saturate to the full geometry
    drain_results();
    write_reg(REG_ROWS, 9'd511);
    write_reg(REG_COLS, 9'd300);
    send_word(CMD_SELECT, 1'b1, 17'd65536, 8'd0, 8'd0);
    send_word(CMD_MARK, 1'b1, 17'd0, 8'd128, 8'd64);
    send_word(CMD_SELECT, 1'b1, 17'd65535, 8'd0, 8'd0);

    // Random phases, one geometry each; the last one runs without idling
    for (p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      write_reg(REG_ROWS, CFG_W'(PHASE_ROWS[p]));
      write_reg(REG_COLS, CFG_W'(PHASE_COLS[p]));
      calm = (p == NUM_PHASES - 1);
      for (n = 0; n < PHASE_WORDS; n++) begin
        if (!calm && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 10));
        else if (!calm && $urandom_range(0, 63) == 0) drain_results();
        random_word();
      end
    end

    drain_results();
    repeat (50) @(posedge clk);
    $display("Covered %0d command words over %0d geometries with random stalls on both sides.",
             ledger.words_in, NUM_PHASES + 4);
    $display("Answers: ok %0d, no free slot %0d, already used %0d, out of range %0d.",
             ledger.status_seen[ST_OK], ledger.status_seen[ST_NO_FREE],
             ledger.status_seen[ST_USED], ledger.status_seen[ST_RANGE]);
    if (ledger.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
